// File: src/htd_pkg.sv
// types and constants shared by the huffman tree decoder
package htd_pkg;

    localparam int LINK_W     = 9;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 8;
    localparam int REM_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int BIT_CNT_W  = 3;

    // request opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SYMBOLS = 1'b1;

    localparam logic [LINK_W-1:0] MIN_COUNT = 9'd2;
    localparam logic [LINK_W-1:0] LINK_NULL = 9'h1ff;

    typedef struct packed {
        logic              op;
        logic [LINK_W-1:0] node_index;
        logic [LINK_W-1:0] left_link;
        logic [LINK_W-1:0] right_link;
        logic [CODE_W-1:0] code_byte;
    } htd_in_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             stream_done;
    } htd_out_t;

    typedef enum logic [1:0] {
        HTD_IDLE,
        HTD_STEP,
        HTD_SYM,
        HTD_FLUSH
    } htd_state_t;

endpackage

// File: src/huffman_tree_decoder.sv
// huffman decoder walking a code tree held in an on-chip node memory
//
//  channel  dir  handshake                   payload
//  in       in   in_valid / in_ready         in_data  (htd_in_t: node load or code byte)
//  out      out  out_valid / out_ready       out_data (htd_out_t: one decoded symbol)
//  cfg      in   cfg_write                   cfg_index, cfg_data
//
// a node load request is written to the node memory as it is accepted. a code byte
// walks the tree one code bit per step, with an extra symbol step for each bit that
// lands on a leaf, and a flush step sends the final symbol; the walk ends early when
// the stream ends in the byte, and none starts if nothing is left to decode. the loop is
// the node memory read port, since each node address comes from the previous read.
// reset clears the walk to the root of a two-symbol tree with nothing to decode;
// the node memory is not cleared. a stalled output holds the walk at the next leaf.
module huffman_tree_decoder
    import htd_pkg::*;
#(
    parameter int MAX_SYMBOLS = 256
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  htd_in_t               in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output htd_out_t              out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // tree holds 2*n-1 nodes; address width follows from that
    localparam int TREE_DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int ADDR_W     = $clog2(TREE_DEPTH);
    localparam logic [LINK_W-1:0] MAX_COUNT = LINK_W'(MAX_SYMBOLS);

    // node memory: left link in the upper half, right link in the lower half
    logic [2*LINK_W-1:0] tree_mem [0:TREE_DEPTH-1];
    logic [2*LINK_W-1:0] rd_data_reg;
    logic [LINK_W-1:0]   rd_addr;

    htd_state_t           state_reg, state_next;
    logic [LINK_W-1:0]    cur_node_reg, cur_node_next;
    logic [LINK_W-1:0]    count_reg, count_next;
    logic [LINK_W-1:0]    root_reg, root_next;
    logic [REM_W-1:0]     remaining_reg, remaining_next;
    logic [CODE_W-1:0]    shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]     pend_sym_reg, pend_sym_next;
    logic                 pend_done_reg, pend_done_next;
    logic                 out_valid_reg, out_valid_next;
    htd_out_t             out_data_reg, out_data_next;

    logic              in_accept;
    logic              load_req;
    logic              out_free;
    logic              sym_take;
    logic              last_bit;
    logic [LINK_W-1:0] rd_left;
    logic [LINK_W-1:0] rd_right;
    logic [LINK_W-1:0] link;
    logic              is_leaf;
    logic [LINK_W-1:0] cfg_count;
    logic [LINK_W-1:0] cfg_root;

    assign in_ready  = (state_reg == HTD_IDLE);
    assign in_accept = in_valid && in_ready;
    assign load_req  = in_accept && (in_data.op == OP_LOAD);
    assign out_free  = !out_valid_reg || out_ready;
    // a new symbol may enter the pending slot once the old one can move out
    assign sym_take  = !pend_valid_reg || out_free;
    assign last_bit  = (bit_cnt_reg == BIT_CNT_W'(CODE_W - 1));

    assign rd_left  = rd_data_reg[2*LINK_W-1:LINK_W];
    assign rd_right = rd_data_reg[LINK_W-1:0];
    // msb first: one goes right, zero goes left
    assign link     = shift_reg[CODE_W-1] ? rd_right : rd_left;
    assign is_leaf  = (link < count_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // symbol count saturated to the legal range, root is 2*count-2
    always_comb
    begin
        if (cfg_data[LINK_W-1:0] < MIN_COUNT)
        begin
            cfg_count = MIN_COUNT;
        end
        else if (cfg_data[LINK_W-1:0] > MAX_COUNT)
        begin
            cfg_count = MAX_COUNT;
        end
        else
        begin
            cfg_count = cfg_data[LINK_W-1:0];
        end
        cfg_root = LINK_W'((cfg_count - LINK_W'(1)) << 1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            HTD_IDLE:
            begin
                if (in_accept && (in_data.op == OP_DECODE) && (remaining_reg != '0))
                begin
                    state_next = HTD_STEP;
                end
            end
            HTD_STEP:
            begin
                if (is_leaf)
                begin
                    state_next = HTD_SYM;
                end
                else if (last_bit)
                begin
                    state_next = HTD_FLUSH;
                end
            end
            HTD_SYM:
            begin
                if (sym_take)
                begin
                    if ((remaining_reg == REM_W'(1)) || last_bit)
                    begin
                        state_next = HTD_FLUSH;
                    end
                    else
                    begin
                        state_next = HTD_STEP;
                    end
                end
            end
            HTD_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = HTD_IDLE;
                end
            end
            default:
            begin
                state_next = HTD_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_node_next   = cur_node_reg;
        count_next      = count_reg;
        root_next       = root_reg;
        remaining_next  = remaining_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        unique case (state_reg)
            HTD_IDLE:
            begin
                if (cfg_write)
                begin
                    unique case (cfg_index)
                        CFG_SYMBOL_COUNT:
                        begin
                            count_next    = cfg_count;
                            root_next     = cfg_root;
                            cur_node_next = cfg_root;
                        end
                        CFG_TOTAL_SYMBOLS:
                        begin
                            remaining_next = cfg_data[REM_W-1:0];
                            cur_node_next  = root_reg;
                        end
                        default:
                        begin
                            cur_node_next = cur_node_reg;
                        end
                    endcase
                end
                if (in_accept && (in_data.op == OP_DECODE))
                begin
                    shift_next   = in_data.code_byte;
                    bit_cnt_next = '0;
                end
            end
            HTD_STEP:
            begin
                // consume one code bit, the walk moves to the chosen link
                cur_node_next = link;
                shift_next    = {shift_reg[CODE_W-2:0], 1'b0};
                if (!is_leaf)
                begin
                    bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                end
            end
            HTD_SYM:
            begin
                // read data now holds the leaf; its left link carries the symbol
                if (sym_take)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{symbol: pend_sym_reg, last: 1'b0,
                                           stream_done: pend_done_reg};
                    end
                    pend_valid_next = 1'b1;
                    pend_sym_next   = rd_left[SYM_W-1:0];
                    pend_done_next  = (remaining_reg == REM_W'(1));
                    remaining_next  = remaining_reg - REM_W'(1);
                    cur_node_next   = root_reg;
                    bit_cnt_next    = bit_cnt_reg + BIT_CNT_W'(1);
                end
            end
            HTD_FLUSH:
            begin
                // last symbol of the byte leaves with its end mark
                if (pend_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '{symbol: pend_sym_reg, last: 1'b1,
                                        stream_done: pend_done_reg};
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                cur_node_next = cur_node_reg;
            end
        endcase
    end

    // the read always follows the node the walk holds next cycle
    assign rd_addr = cur_node_next;

    always_ff @(posedge clk)
    begin
        if (load_req && (in_data.node_index < LINK_W'(TREE_DEPTH)))
        begin
            tree_mem[in_data.node_index[ADDR_W-1:0]] <= {in_data.left_link, in_data.right_link};
        end
        // links beyond the store read as zero
        if (rd_addr < LINK_W'(TREE_DEPTH))
        begin
            rd_data_reg <= tree_mem[rd_addr[ADDR_W-1:0]];
        end
        else
        begin
            rd_data_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= HTD_IDLE;
            cur_node_reg   <= MIN_COUNT;
            count_reg      <= MIN_COUNT;
            root_reg       <= MIN_COUNT;
            remaining_reg  <= '0;
            bit_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            count_reg      <= count_next;
            root_reg       <= root_next;
            remaining_reg  <= remaining_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        pend_sym_reg  <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        out_data_reg  <= out_data_next;
    end

    // a walk only runs while symbols are still owed
    a_step_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HTD_STEP) |-> (remaining_reg != '0))
        else $error("walk running with no symbols remaining");

    // the end-of-stream symbol always closes its byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.stream_done) |-> out_data.last)
        else $error("stream end without last mark");

    // nothing pending when a new request may enter
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !pend_valid_reg)
        else $error("pending symbol left behind at idle");

    // each taken leaf costs exactly one symbol of the count
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == HTD_SYM) && sym_take) |=>
            (remaining_reg == $past(remaining_reg) - REM_W'(1)))
        else $error("remaining count not decremented on symbol");

endmodule
